// ===== hdl/mpp_pkg.sv =====
// shared types and constants of the mirror padding block
package mpp_pkg;

  // configuration register file
  localparam int unsigned CFG_BITS = 9;
  localparam int unsigned CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_TOP      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_BOTTOM   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_BEFORE   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_AFTER    = 3'd5;

  localparam logic [CFG_BITS-1:0] RESET_SIZE = 9'd256;

  // commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // padded dimensions reach 3 * 511, sizes and pads stay within the register width
  localparam int unsigned TOT_BITS = 11;

  typedef struct packed {
    logic [CFG_BITS-1:0] w;
    logic [CFG_BITS-1:0] h;
    logic [CFG_BITS-1:0] pt;
    logic [CFG_BITS-1:0] pb;
    logic [CFG_BITS-1:0] pl;
    logic [CFG_BITS-1:0] pr;
    logic [TOT_BITS-1:0] tot_w;
    logic [TOT_BITS-1:0] tot_h;
  } geom_t;

endpackage

// ===== hdl/mirror_pad_plane.sv =====
// top level of the symmetric mirror padding block with its frame store
//
// usage
// - input channel (in_valid_i / in_ready_o) carries command_i and pixel_in_i; a load
//   command writes pixel_in_i at the next row-major source position, a fetch command
//   asks for the next pixel of the padded plane
// - output channel (out_valid_o / out_ready_i) carries pixel_out_o and plane_end_o,
//   one transfer per fetch, none per load; plane_end_o marks the last padded pixel
// - config port: cfg_we_i writes cfg_data_i into register cfg_index_i; write only
//   while the block is idle, not enforced by the block; unknown indexes are ignored
// - throughput is one item per cycle while in_ready_o is high, set by the
//   single-port frame store that takes one write or one read each cycle
// - the frame store read data is held in a stage register, the output register
//   behind it lets the input keep moving while a result waits
// - when the receiver stalls the two stages fill and in_ready_o drops
// - reset clears positions, pipeline valids and restores the reset geometry;
//   the frame store is not cleared, a never-loaded entry reads as garbage
module mirror_pad_plane import mpp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    command_i,
  input  logic [PIXEL_BITS-1:0]   pixel_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [PIXEL_BITS-1:0]   pixel_out_o,
  output logic                    plane_end_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  // rows are laid out on a power-of-two pitch so the address is a concatenation
  localparam int unsigned DEPTH = MAX_HEIGHT << CW;

  geom_t geom;

  logic          in_xfer, do_load, do_fetch, advance;
  logic [RW-1:0] load_row, fetch_row;
  logic [CW-1:0] load_col, fetch_col;
  logic          fetch_end;

  // frame store
  logic [PIXEL_BITS-1:0] store_mem [DEPTH];
  logic [PIXEL_BITS-1:0] rd_q;

  // read stage and output register
  logic                  s1_valid_q, s1_end_q;
  logic                  out_valid_q, plane_end_q;
  logic [PIXEL_BITS-1:0] pixel_out_q;

  mpp_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom)
  );

  mpp_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_addr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .load_i      (do_load),
    .fetch_i     (do_fetch),
    .load_row_o  (load_row),
    .load_col_o  (load_col),
    .fetch_row_o (fetch_row),
    .fetch_col_o (fetch_col),
    .plane_end_o (fetch_end)
  );

  // read stage moves on when the output register is empty or being drained
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign do_load    = in_xfer && (command_i == CMD_LOAD);
  assign do_fetch   = in_xfer && (command_i == CMD_FETCH);

  // one access per cycle: a load writes, a fetch reads into rd_q
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      store_mem[{load_row, load_col}] <= pixel_in_i;
    end
    if (do_fetch) begin
      rd_q <= store_mem[{fetch_row, fetch_col}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_fetch) s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
      if (advance) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_fetch) s1_end_q <= fetch_end;
    if (advance) begin
      pixel_out_q <= rd_q;
      plane_end_q <= s1_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign plane_end_o = plane_end_q;

endmodule

// ===== hdl/mpp_cfg.sv =====
// configuration registers and the clamped plane geometry derived from them
module mpp_cfg import mpp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  output geom_t                   geom_o
);

  localparam int unsigned WCAP = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
  localparam int unsigned HCAP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

  logic [CFG_BITS-1:0] width_q, height_q, top_q, bottom_q, before_q, after_q;
  logic [CFG_BITS-1:0] w, h, pt, pb, pl, pr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_SIZE;
      height_q <= RESET_SIZE;
      top_q    <= '0;
      bottom_q <= '0;
      before_q <= '0;
      after_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PLANE_WIDTH:  width_q  <= cfg_data_i;
        REG_PLANE_HEIGHT: height_q <= cfg_data_i;
        REG_PAD_TOP:      top_q    <= cfg_data_i;
        REG_PAD_BOTTOM:   bottom_q <= cfg_data_i;
        REG_PAD_BEFORE:   before_q <= cfg_data_i;
        REG_PAD_AFTER:    after_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates, pads clamp to the size
  always_comb begin
    if (width_q == '0) w = CFG_BITS'(1);
    else if (width_q > CFG_BITS'(WCAP)) w = CFG_BITS'(WCAP);
    else w = width_q;
    if (height_q == '0) h = CFG_BITS'(1);
    else if (height_q > CFG_BITS'(HCAP)) h = CFG_BITS'(HCAP);
    else h = height_q;
    pt = (top_q > h) ? h : top_q;
    pb = (bottom_q > h) ? h : bottom_q;
    pl = (before_q > w) ? w : before_q;
    pr = (after_q > w) ? w : after_q;
  end

  assign geom_o.w     = w;
  assign geom_o.h     = h;
  assign geom_o.pt    = pt;
  assign geom_o.pb    = pb;
  assign geom_o.pl    = pl;
  assign geom_o.pr    = pr;
  assign geom_o.tot_w = TOT_BITS'(w) + TOT_BITS'(pl) + TOT_BITS'(pr);
  assign geom_o.tot_h = TOT_BITS'(h) + TOT_BITS'(pt) + TOT_BITS'(pb);

endmodule

// ===== hdl/mpp_addr.sv =====
// load and fetch position counters and the mirrored store address
module mpp_addr import mpp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned CW         = $clog2(MAX_WIDTH),
  parameter int unsigned RW         = $clog2(MAX_HEIGHT)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  geom_t         geom_i,
  input  logic          load_i,
  input  logic          fetch_i,
  output logic [RW-1:0] load_row_o,
  output logic [CW-1:0] load_col_o,
  output logic [RW-1:0] fetch_row_o,
  output logic [CW-1:0] fetch_col_o,
  output logic          plane_end_o
);

  function automatic logic [CFG_BITS-1:0] mirror(input logic [TOT_BITS-1:0] i,
                                                 input logic [CFG_BITS-1:0] lead,
                                                 input logic [CFG_BITS-1:0] size);
    logic [TOT_BITS-1:0] b, s, r;
    b = TOT_BITS'(lead);
    s = TOT_BITS'(size);
    if (i < b) r = b - TOT_BITS'(1) - i;
    else if (i < b + s) r = i - b;
    else r = (s << 1) + b - TOT_BITS'(1) - i;
    return CFG_BITS'(r);
  endfunction

  logic [CFG_BITS-1:0] lrow_q, lcol_q, lrow_d, lcol_d, lrow, lcol;
  logic [TOT_BITS-1:0] orow_q, ocol_q, orow_d, ocol_d, orow, ocol;
  logic                lcol_wrap, ocol_wrap, orow_last;
  logic [CFG_BITS-1:0] src_row, src_col;

  // stale positions restart at the origin
  always_comb begin
    lcol = (lcol_q >= geom_i.w) ? '0 : lcol_q;
    lrow = (lrow_q >= geom_i.h) ? '0 : lrow_q;
    ocol = (ocol_q >= geom_i.tot_w) ? '0 : ocol_q;
    orow = (orow_q >= geom_i.tot_h) ? '0 : orow_q;

    lcol_wrap = (lcol == geom_i.w - CFG_BITS'(1));
    lcol_d    = lcol_wrap ? '0 : lcol + CFG_BITS'(1);
    if (!lcol_wrap) lrow_d = lrow;
    else if (lrow == geom_i.h - CFG_BITS'(1)) lrow_d = '0;
    else lrow_d = lrow + CFG_BITS'(1);

    ocol_wrap = (ocol == geom_i.tot_w - TOT_BITS'(1));
    orow_last = (orow == geom_i.tot_h - TOT_BITS'(1));
    ocol_d    = ocol_wrap ? '0 : ocol + TOT_BITS'(1);
    if (!ocol_wrap) orow_d = orow;
    else if (orow_last) orow_d = '0;
    else orow_d = orow + TOT_BITS'(1);

    src_row = mirror(orow, geom_i.pt, geom_i.h);
    src_col = mirror(ocol, geom_i.pl, geom_i.w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lrow_q <= '0;
      lcol_q <= '0;
      orow_q <= '0;
      ocol_q <= '0;
    end else begin
      if (load_i) begin
        lrow_q <= lrow_d;
        lcol_q <= lcol_d;
      end
      if (fetch_i) begin
        orow_q <= orow_d;
        ocol_q <= ocol_d;
      end
    end
  end

  assign load_row_o  = RW'(lrow);
  assign load_col_o  = CW'(lcol);
  assign fetch_row_o = RW'(src_row);
  assign fetch_col_o = CW'(src_col);
  assign plane_end_o = orow_last && ocol_wrap;

endmodule

// ===== tb/sv/mpp_checker.sv =====
// checker for the mirror padding block: watches the ports, predicts the padded pixels, compares
`timescale 1ns / 1ps
module mpp_checker import mpp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    command_i,
  input  logic [PIXEL_BITS-1:0]   pixel_in_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [PIXEL_BITS-1:0]   pixel_out_i,
  input  logic                    plane_end_i,
  output int                      mismatch_count_o,
  output int                      backlog_o,
  output int                      checked_o
);

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  last;
  } padded_pix_t;

  padded_pix_t           padded_q [$];
  padded_pix_t           oldest;
  logic [PIXEL_BITS-1:0] source_plane [MAX_WIDTH*MAX_HEIGHT];

  logic [CFG_BITS-1:0] width_reg, height_reg, top_reg, bottom_reg, before_reg, after_reg;
  int unsigned         load_r, load_c, scan_r, scan_c;

  function automatic int unsigned clip_size(logic [CFG_BITS-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned clip_pad(logic [CFG_BITS-1:0] p, int unsigned span);
    return (p > span) ? span : p;
  endfunction

  // edge-including reflection of one padded coordinate back into the source plane
  function automatic int unsigned fold_index(int unsigned i, int unsigned lead,
                                             int unsigned span);
    if (i < lead) return lead - 1 - i;
    if (i < lead + span) return i - lead;
    return 2 * span + lead - 1 - i;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count_o++;
  endtask

  task automatic store_pixel(input logic [PIXEL_BITS-1:0] pix);
    int unsigned w, h;
    w = clip_size(width_reg, MAX_WIDTH);
    h = clip_size(height_reg, MAX_HEIGHT);
    // positions left over from a larger geometry restart at zero
    if (load_c >= w) load_c = 0;
    if (load_r >= h) load_r = 0;
    source_plane[load_r * MAX_WIDTH + load_c] = pix;
    load_c++;
    if (load_c >= w) begin
      load_c = 0;
      load_r++;
      if (load_r >= h) load_r = 0;
    end
  endtask

  task automatic predict_padded();
    int unsigned w, h, pt, pb, pl, pr, tot_w, tot_h, sr, sc;
    padded_pix_t nxt;
    w = clip_size(width_reg, MAX_WIDTH);
    h = clip_size(height_reg, MAX_HEIGHT);
    pt = clip_pad(top_reg, h);
    pb = clip_pad(bottom_reg, h);
    pl = clip_pad(before_reg, w);
    pr = clip_pad(after_reg, w);
    tot_h = h + pt + pb;
    tot_w = w + pl + pr;
    if (scan_c >= tot_w) scan_c = 0;
    if (scan_r >= tot_h) scan_r = 0;
    sr = fold_index(scan_r, pt, h);
    sc = fold_index(scan_c, pl, w);
    nxt.pixel = source_plane[sr * MAX_WIDTH + sc];
    nxt.last = (scan_r == tot_h - 1) && (scan_c == tot_w - 1);
    padded_q = {padded_q, nxt};
    scan_c++;
    if (scan_c >= tot_w) begin
      scan_c = 0;
      scan_r++;
      if (scan_r >= tot_h) scan_r = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      padded_q.delete();
      width_reg = RESET_SIZE;
      height_reg = RESET_SIZE;
      top_reg = '0;
      bottom_reg = '0;
      before_reg = '0;
      after_reg = '0;
      load_r = 0;
      load_c = 0;
      scan_r = 0;
      scan_c = 0;
      mismatch_count_o = 0;
      checked_o = 0;
      backlog_o <= 0;
    end else begin
      // output transfer first: it always belongs to an earlier fetch
      if (out_valid_i && out_ready_i) begin
        if (padded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result pixel=%h end=%b",
                                    pixel_out_i, plane_end_i));
        end else begin
          oldest = padded_q.pop_front();
          checked_o++;
          if (pixel_out_i !== oldest.pixel)
            report_mismatch($sformatf("pixel_out %h, predicted %h", pixel_out_i, oldest.pixel));
          if (plane_end_i !== oldest.last)
            report_mismatch($sformatf("plane_end %b, predicted %b", plane_end_i, oldest.last));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PLANE_WIDTH:  width_reg = cfg_data_i;
          REG_PLANE_HEIGHT: height_reg = cfg_data_i;
          REG_PAD_TOP:      top_reg = cfg_data_i;
          REG_PAD_BOTTOM:   bottom_reg = cfg_data_i;
          REG_PAD_BEFORE:   before_reg = cfg_data_i;
          REG_PAD_AFTER:    after_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (command_i == CMD_LOAD) store_pixel(pixel_in_i);
        else predict_padded();
      end
      backlog_o <= padded_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// top of the mirror padding testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
  import mpp_pkg::*;

  localparam int unsigned MAX_W = 256;
  localparam int unsigned MAX_H = 256;
  localparam int unsigned PIX_W = 32;

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = REG_PLANE_WIDTH;
  logic [CFG_BITS-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    command_i = CMD_LOAD;
  logic [PIX_W-1:0]        pixel_in_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [PIX_W-1:0]        pixel_out_o;
  logic                    plane_end_o;

  int mismatch_count, backlog, checked;

  // idle odds in percent, changed per regime
  int in_idle_pct = 0;
  int out_idle_pct = 0;

  int items_sent = 0;
  int load_count = 0;
  int fetch_count = 0;
  int geometry_count = 0;
  int drain_cycles = 0;
  int target;

  mirror_pad_plane #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .PIXEL_BITS(PIX_W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .pixel_in_i (pixel_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_out_o(pixel_out_o),
    .plane_end_o(plane_end_o)
  );

  mpp_checker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .PIXEL_BITS(PIX_W)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .command_i       (command_i),
    .pixel_in_i      (pixel_in_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_out_i     (pixel_out_o),
    .plane_end_i     (plane_end_o),
    .mismatch_count_o(mismatch_count),
    .backlog_o       (backlog),
    .checked_o       (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random back-pressure, one decision per cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout: transfers stopped moving");
    $display("Regression FAIL");
    $finish;
  end

  // effective size as the block sees it, needed to know how many loads fill the plane
  function automatic int unsigned span_of(logic [CFG_BITS-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // sizes at or past the maximum, including the saturating ones
  function automatic logic [CFG_BITS-1:0] pick_full_span();
    case ($urandom_range(0, 2))
      0: return RESET_SIZE;
      1: return '1;
      default: return CFG_BITS'($urandom_range(257, 510));
    endcase
  endfunction

  // pads: mostly small, sometimes far beyond any size so the clamp is exercised
  function automatic logic [CFG_BITS-1:0] pick_pad();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return RESET_SIZE;
      2, 3, 4, 5: return CFG_BITS'($urandom_range(0, 2));
      default: return CFG_BITS'($urandom_range(0, 9));
    endcase
  endfunction

  // one input transfer; valid only drops when the sender decides to idle
  task automatic send_item(input logic cmd, input logic [PIX_W-1:0] pix);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (cmd == CMD_LOAD) load_count++;
    else fetch_count++;
  endtask

  // hold the sender until every predicted pixel came out, then let loads settle
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // writes all six registers on consecutive cycles; returns the pixels in one plane
  task automatic program_geometry(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h,
                                  input logic [CFG_BITS-1:0] pt, input logic [CFG_BITS-1:0] pb,
                                  input logic [CFG_BITS-1:0] pl, input logic [CFG_BITS-1:0] pr,
                                  output int unsigned plane_pixels);
    logic [CFG_IDX_BITS-1:0] reg_sel [6];
    logic [CFG_BITS-1:0]     reg_val [6];
    reg_sel = '{REG_PLANE_WIDTH, REG_PLANE_HEIGHT, REG_PAD_TOP,
                REG_PAD_BOTTOM, REG_PAD_BEFORE, REG_PAD_AFTER};
    reg_val = '{w, h, pt, pb, pl, pr};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= reg_sel[i];
      cfg_data_i <= reg_val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    geometry_count++;
    plane_pixels = span_of(w, MAX_W) * span_of(h, MAX_H);
  endtask

  // new geometry, a full plane of loads so no fetch can touch an unwritten entry,
  // then a mix that mostly fetches and sometimes overwrites source pixels
  task automatic run_phase();
    logic [CFG_BITS-1:0] w, h;
    int unsigned         plane_pixels, mix_len;
    if ($urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 1) == 1) begin
        w = pick_full_span();
        h = CFG_BITS'($urandom_range(0, 1));
      end else begin
        h = pick_full_span();
        w = CFG_BITS'($urandom_range(0, 1));
      end
    end else if ($urandom_range(0, 9) < 4) begin
      w = CFG_BITS'($urandom_range(0, 3));
      h = CFG_BITS'($urandom_range(0, 3));
    end else begin
      w = CFG_BITS'($urandom_range(0, 7));
      h = CFG_BITS'($urandom_range(0, 7));
    end
    quiesce();
    program_geometry(w, h, pick_pad(), pick_pad(), pick_pad(), pick_pad(), plane_pixels);
    for (int unsigned i = 0; i < plane_pixels; i++) send_item(CMD_LOAD, $urandom);
    mix_len = $urandom_range(5, 60);
    for (int unsigned i = 0; i < mix_len; i++) begin
      if ($urandom_range(0, 9) < 7) send_item(CMD_FETCH, $urandom);
      else send_item(CMD_LOAD, $urandom);
    end
  endtask

  initial begin
    int unsigned plane_pixels;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero width acts as one, top and left pads clamp, bottom row mirrors the last one;
    // twelve fetches cross the end of the 5x2 plane and wrap
    program_geometry('0, 9'd2, 9'd3, 9'd1, 9'd5, '0, plane_pixels);
    send_item(CMD_LOAD, '0);
    send_item(CMD_LOAD, '1);
    repeat (12) send_item(CMD_FETCH, '0);

    // zero height acts as one, right pad equals the width
    quiesce();
    program_geometry(9'd2, '0, '0, '0, '0, 9'd2, plane_pixels);
    send_item(CMD_LOAD, 32'hAAAA_AAAA);
    send_item(CMD_LOAD, 32'h5555_5555);
    repeat (5) send_item(CMD_FETCH, '1);

    // three regimes: sender rarely idle, receiver rarely idle, then no idling at all
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          in_idle_pct = 10;
          out_idle_pct = 65;
        end
        1: begin
          in_idle_pct = 65;
          out_idle_pct = 10;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
      endcase
      target = items_sent + 250;
      while (items_sent < target) run_phase();
    end

    // drain: wait for the last results, bounded
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (8) @(posedge clk_i);

    if (backlog != 0) $display("%0d predicted pixels never came out", backlog);
    $display("covered %0d loads and %0d fetches across %0d geometry settings",
             load_count, fetch_count, geometry_count);
    $display("%0d padded pixels compared under three idle regimes", checked);
    if (mismatch_count == 0 && backlog == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mpp_pkg.sv
hdl/mpp_cfg.sv
hdl/mpp_addr.sv
hdl/mirror_pad_plane.sv
tb/sv/mpp_checker.sv
tb/sv/tb_top.sv
